[hdl/qtp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the QUIC transport-parameter parser.
package qtp_pkg;

  // Result kinds seen on the output side
  typedef enum logic [1:0] {
    KIND_VALUE    = 2'd0,
    KIND_CID_BYTE = 2'd1,
    KIND_STATUS   = 2'd2
  } kind_t;

  // Parse phase of the front end
  typedef enum logic [1:0] {
    PH_ID    = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  // Handling class of a parameter id
  typedef enum logic [1:0] {
    CAT_SKIP = 2'd0,
    CAT_CID  = 2'd1,
    CAT_VAR  = 2'd2,
    CAT_FLAG = 2'd3
  } cat_t;

  localparam int ID_W    = 5;
  localparam int VALUE_W = 62;
  localparam int IDX_W   = 5;

  // Defaults for top-level parameters
  localparam int MAX_CID_BYTES_DEF = 20;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Parameter ids with special handling
  localparam logic [ID_W-1:0] ID_ORIG_DCID       = 5'd0;
  localparam logic [ID_W-1:0] ID_MAX_UDP_PAYLOAD = 5'd3;
  localparam logic [ID_W-1:0] ID_ACK_DELAY_EXP   = 5'd10;
  localparam logic [ID_W-1:0] ID_MAX_ACK_DELAY   = 5'd11;
  localparam logic [ID_W-1:0] ID_MIGRATION       = 5'd12;
  localparam logic [ID_W-1:0] ID_CID_LIMIT       = 5'd14;
  localparam logic [ID_W-1:0] ID_INIT_SCID       = 5'd15;
  localparam logic [ID_W-1:0] ID_RETRY_SCID      = 5'd16;

  // Value limits
  localparam logic [VALUE_W-1:0] MIN_UDP_PAYLOAD = 62'd1200;
  localparam logic [VALUE_W-1:0] MAX_ACK_EXP     = 62'd20;
  localparam logic [VALUE_W-1:0] ACK_DELAY_LIMIT = 62'd16384;
  localparam logic [VALUE_W-1:0] MIN_CID_LIMIT   = 62'd2;

  // One queue entry: everything a single input byte produced
  typedef struct packed {
    logic               has_val;
    kind_t              kind;
    logic [ID_W-1:0]    id;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   idx;
    logic               has_status;
    logic               failed;
  } qtp_entry_t;

endpackage

[hdl/qtp_front.sv]
`timescale 1ns / 1ps
// Front end: per-byte varint and parameter parsing, builds at most one queue entry per byte.
module qtp_front import qtp_pkg::*; #(
  parameter int MAX_CID_BYTES = MAX_CID_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       block_end,
  output logic       wr,
  output qtp_entry_t wr_data
);

  phase_t             phase, phase_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic [2:0]         var_left, var_left_next;
  logic [ID_W-1:0]    cur_id, cur_id_next;
  logic               id_small, id_small_next;
  logic [VALUE_W-1:0] val_left, val_left_next;
  logic [3:0]         val_len, val_len_next;
  logic [31:0]        seen, seen_next;
  logic               err, err_next;
  logic [IDX_W-1:0]   cid_pos, cid_pos_next;

  cat_t               cat;
  logic               first;
  logic [VALUE_W-1:0] acc_v;
  logic [2:0]         left_v;
  logic               adv;

  // Classify the current parameter id
  function automatic cat_t classify(input logic is_small, input logic [ID_W-1:0] id);
    cat_t c;
    c = CAT_SKIP;
    if (is_small) begin
      if (id inside {ID_ORIG_DCID, ID_INIT_SCID, ID_RETRY_SCID}) c = CAT_CID;
      else if (id == ID_MIGRATION) c = CAT_FLAG;
      else if (id inside {5'd1, [5'd3:5'd11], 5'd14}) c = CAT_VAR;
    end
    return c;
  endfunction

  // Range check on a decoded parameter value
  function automatic logic value_ok(input logic [ID_W-1:0] id, input logic [VALUE_W-1:0] v);
    logic ok;
    case (id)
      ID_MAX_UDP_PAYLOAD: ok = (v >= MIN_UDP_PAYLOAD);
      ID_ACK_DELAY_EXP:   ok = (v <= MAX_ACK_EXP);
      ID_MAX_ACK_DELAY:   ok = (v < ACK_DELAY_LIMIT);
      ID_CID_LIMIT:       ok = (v >= MIN_CID_LIMIT);
      default:            ok = 1'b1;
    endcase
    return ok;
  endfunction

  assign cat   = classify(id_small, cur_id);
  assign first = (val_left == {{(VALUE_W-4){1'b0}}, val_len});

  // Next state and queue entry for the accepted byte
  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    var_left_next = var_left;
    cur_id_next   = cur_id;
    id_small_next = id_small;
    val_left_next = val_left;
    val_len_next  = val_len;
    seen_next     = seen;
    err_next      = err;
    cid_pos_next  = cid_pos;
    wr_data       = '0;
    acc_v         = acc;
    left_v        = var_left;
    adv           = 1'b0;

    if (accept && !err) begin
      if (phase == PH_VALUE) begin
        case (cat)
          CAT_CID: begin
            wr_data.has_val = 1'b1;
            wr_data.kind    = KIND_CID_BYTE;
            wr_data.id      = cur_id;
            wr_data.value   = {{(VALUE_W-8){1'b0}}, data_byte};
            wr_data.idx     = cid_pos;
            cid_pos_next    = cid_pos + 5'd1;
            adv             = 1'b1;
          end
          CAT_VAR: begin
            if (first && ((4'd1 << data_byte[7:6]) != val_len)) begin
              err_next = 1'b1;
            end else begin
              acc_v    = first ? {{(VALUE_W-6){1'b0}}, data_byte[5:0]}
                               : {acc[VALUE_W-9:0], data_byte};
              acc_next = acc_v;
              if (val_left == 62'd1) begin
                if (!value_ok(cur_id, acc_v)) begin
                  err_next = 1'b1;
                end else begin
                  wr_data.has_val = 1'b1;
                  wr_data.kind    = KIND_VALUE;
                  wr_data.id      = cur_id;
                  wr_data.value   = acc_v;
                  adv             = 1'b1;
                end
              end else begin
                adv = 1'b1;
              end
            end
          end
          default: adv = 1'b1;
        endcase
        // Count down the value bytes
        if (adv) begin
          val_left_next = val_left - 62'd1;
          if (val_left == 62'd1) phase_next = PH_ID;
        end
      end else begin
        // Accumulate an id or length varint
        if (var_left == 3'd0) begin
          left_v = 3'((4'd1 << data_byte[7:6]) - 4'd1);
          acc_v  = {{(VALUE_W-6){1'b0}}, data_byte[5:0]};
        end else begin
          left_v = var_left - 3'd1;
          acc_v  = {acc[VALUE_W-9:0], data_byte};
        end
        acc_next      = acc_v;
        var_left_next = left_v;
        if (left_v == 3'd0) begin
          if (phase == PH_LEN) begin
            phase_next = PH_ID;
            case (cat)
              CAT_CID: begin
                if (acc_v > VALUE_W'(MAX_CID_BYTES)) begin
                  err_next = 1'b1;
                end else begin
                  wr_data.has_val = 1'b1;
                  wr_data.kind    = KIND_VALUE;
                  wr_data.id      = cur_id;
                  wr_data.value   = acc_v;
                  cid_pos_next    = '0;
                  val_left_next   = acc_v;
                  if (acc_v != '0) phase_next = PH_VALUE;
                end
              end
              CAT_VAR: begin
                if (acc_v == '0 || acc_v > 62'd8) begin
                  err_next = 1'b1;
                end else begin
                  val_len_next  = acc_v[3:0];
                  val_left_next = acc_v;
                  phase_next    = PH_VALUE;
                end
              end
              CAT_FLAG: begin
                if (acc_v != '0) begin
                  err_next = 1'b1;
                end else begin
                  wr_data.has_val = 1'b1;
                  wr_data.kind    = KIND_VALUE;
                  wr_data.id      = cur_id;
                  wr_data.value   = 62'd1;
                end
              end
              default: begin
                val_left_next = acc_v;
                if (acc_v != '0) phase_next = PH_VALUE;
              end
            endcase
          end else begin
            // Id complete: check for duplicates among small ids
            id_small_next = (acc_v[VALUE_W-1:ID_W] == '0);
            cur_id_next   = acc_v[ID_W-1:0];
            if (id_small_next) begin
              if (seen[acc_v[ID_W-1:0]]) err_next = 1'b1;
              seen_next[acc_v[ID_W-1:0]] = 1'b1;
            end
            phase_next = PH_LEN;
          end
        end
      end
    end

    // Close the block: report status and return to the start state
    if (accept && block_end) begin
      wr_data.has_status = 1'b1;
      wr_data.failed     = err_next || (phase_next != PH_ID) || (var_left_next != 3'd0);
      phase_next    = PH_ID;
      acc_next      = '0;
      var_left_next = '0;
      cur_id_next   = '0;
      id_small_next = 1'b0;
      val_left_next = '0;
      val_len_next  = '0;
      seen_next     = '0;
      err_next      = 1'b0;
      cid_pos_next  = '0;
    end

    wr = accept && (wr_data.has_val || wr_data.has_status);
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_ID;
      acc      <= '0;
      var_left <= '0;
      cur_id   <= '0;
      id_small <= 1'b0;
      val_left <= '0;
      val_len  <= '0;
      seen     <= '0;
      err      <= 1'b0;
      cid_pos  <= '0;
    end else begin
      phase    <= phase_next;
      acc      <= acc_next;
      var_left <= var_left_next;
      cur_id   <= cur_id_next;
      id_small <= id_small_next;
      val_left <= val_left_next;
      val_len  <= val_len_next;
      seen     <= seen_next;
      err      <= err_next;
      cid_pos  <= cid_pos_next;
    end
  end

endmodule

[hdl/qtp_fifo.sv]
`timescale 1ns / 1ps
// Short queue of per-byte entries between the front end and the output stage.
module qtp_fifo import qtp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  qtp_entry_t wr_data,
  input  logic       rd,
  output qtp_entry_t rd_data,
  output logic       not_empty,
  output logic       full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qtp_entry_t      mem [DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr && !full;
  assign do_rd     = rd && not_empty;
  assign rd_data   = mem[rptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (do_rd) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule

[hdl/qtp_back.sv]
`timescale 1ns / 1ps
// Output stage: splits each queue entry into results and holds them in an output register.
module qtp_back import qtp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  qtp_entry_t         head,
  input  logic               head_valid,
  output logic               deq,
  input  logic               pop,
  output logic               empty,
  output logic [1:0]         kind,
  output logic [ID_W-1:0]    param_id,
  output logic [VALUE_W-1:0] param_value,
  output logic [IDX_W-1:0]   cid_index,
  output logic               failed,
  output logic               last_of_run
);

  logic  out_valid;
  logic  sub;
  logic  load;
  logic  take_val;
  kind_t out_kind;

  assign empty    = !out_valid;
  assign load     = (!out_valid || pop) && head_valid;
  assign take_val = head.has_val && !sub;
  assign deq      = load && !(take_val && head.has_status);
  assign kind     = out_kind;

  // Track which half of a two-result entry goes next
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      sub       <= take_val && head.has_status;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      if (take_val) begin
        out_kind    <= head.kind;
        param_id    <= head.id;
        param_value <= head.value;
        cid_index   <= head.idx;
        failed      <= 1'b0;
        last_of_run <= !head.has_status;
      end else begin
        out_kind    <= KIND_STATUS;
        param_id    <= '0;
        param_value <= '0;
        cid_index   <= '0;
        failed      <= head.failed;
        last_of_run <= 1'b1;
      end
    end
  end

endmodule

[hdl/quic_transport_param_parser.sv]
`timescale 1ns / 1ps
// Top level of the QUIC transport-parameter parser.
//
//   channel   direction  handshake      payload
//   bytes     in         push / full    data_byte, block_end
//   results   out        pop / empty    kind, param_id, param_value, cid_index,
//                                       failed, last_of_run
//
// One byte is taken every cycle while full is low; the front end parses it in that
// cycle and queues what it produced. Its results pass through the queue and then the
// output register, which hands out one result per cycle while results are popped, so
// a byte yielding a value and the block status gives two results; full rises when
// the queue holds QUEUE_DEPTH entries. Reset clears parser state and queue at once.
module quic_transport_param_parser import qtp_pkg::*; #(
  parameter int MAX_CID_BYTES = MAX_CID_BYTES_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               block_end,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind,
  output logic [ID_W-1:0]    param_id,
  output logic [VALUE_W-1:0] param_value,
  output logic [IDX_W-1:0]   cid_index,
  output logic               failed,
  output logic               last_of_run
);

  logic       accept;
  logic       q_wr;
  qtp_entry_t q_wr_data;
  logic       q_rd;
  qtp_entry_t q_head;
  logic       q_not_empty;

  assign accept = push && !full;

  qtp_front #(
    .MAX_CID_BYTES(MAX_CID_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data_byte(data_byte),
    .block_end(block_end),
    .wr       (q_wr),
    .wr_data  (q_wr_data)
  );

  qtp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_data  (q_wr_data),
    .rd       (q_rd),
    .rd_data  (q_head),
    .not_empty(q_not_empty),
    .full     (full)
  );

  qtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_not_empty),
    .deq        (q_rd),
    .pop        (pop),
    .empty      (empty),
    .kind       (kind),
    .param_id   (param_id),
    .param_value(param_value),
    .cid_index  (cid_index),
    .failed     (failed),
    .last_of_run(last_of_run)
  );

  // A status result always closes its run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_STATUS) |-> last_of_run)
    else $error("status result without last_of_run");

  // Only status results carry a rejection
  a_failed_only_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_STATUS) |-> !failed)
    else $error("failed set on a non-status result");

  // Connection-ID byte positions stay below the length limit
  a_cid_index_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_CID_BYTE) |-> (cid_index < IDX_W'(MAX_CID_BYTES)))
    else $error("connection-ID byte index out of range");

endmodule

[dv/qtp_param_checker.sv]
`timescale 1ns / 1ps
// Checker for the QUIC transport-parameter parser: predicts every result and compares.
module qtp_param_checker import qtp_pkg::*; #(
  parameter int MAX_CID_BYTES = MAX_CID_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         data_byte,
  input  logic               block_end,
  input  logic               empty,
  input  logic               pop,
  input  logic [1:0]         kind,
  input  logic [ID_W-1:0]    param_id,
  input  logic [VALUE_W-1:0] param_value,
  input  logic [IDX_W-1:0]   cid_index,
  input  logic               failed,
  input  logic               last_of_run,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    id;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   idx;
    logic               failed;
    logic               last;
  } param_result_t;

  // Results still owed by the block, oldest first
  param_result_t predicted[$];

  // Mirror of the parser state
  phase_t             ph;
  logic [VALUE_W-1:0] acc;
  logic [2:0]         vint_left;
  logic [ID_W-1:0]    cur_id;
  logic               id_small;
  logic [VALUE_W-1:0] val_left;
  logic [3:0]         val_len;
  logic [31:0]        seen;
  logic               err;
  logic [IDX_W-1:0]   cid_pos;

  function automatic void clear_parser();
    ph        = PH_ID;
    acc       = '0;
    vint_left = '0;
    cur_id    = '0;
    id_small  = 1'b0;
    val_left  = '0;
    val_len   = '0;
    seen      = '0;
    err       = 1'b0;
    cid_pos   = '0;
  endfunction

  // Classify the current id; ids of 32 and above are always skipped
  function automatic cat_t id_class();
    if (!id_small) return CAT_SKIP;
    case (cur_id)
      ID_ORIG_DCID, ID_INIT_SCID, ID_RETRY_SCID: return CAT_CID;
      ID_MIGRATION: return CAT_FLAG;
      5'd1, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
      5'd10, 5'd11, 5'd14: return CAT_VAR;
      default: return CAT_SKIP;
    endcase
  endfunction

  // Byte count announced by the two top bits of a varint's first byte
  function automatic logic [3:0] prefix_len(input logic [7:0] b);
    return 4'd1 << b[7:6];
  endfunction

  function automatic bit value_legal(input logic [VALUE_W-1:0] v);
    case (cur_id)
      ID_MAX_UDP_PAYLOAD: return v >= MIN_UDP_PAYLOAD;
      ID_ACK_DELAY_EXP:   return v <= MAX_ACK_EXP;
      ID_MAX_ACK_DELAY:   return v < ACK_DELAY_LIMIT;
      ID_CID_LIMIT:       return v >= MIN_CID_LIMIT;
      default:            return 1'b1;
    endcase
  endfunction

  function automatic void add_result(input kind_t k, input logic [ID_W-1:0] id,
                                     input logic [VALUE_W-1:0] v,
                                     input logic [IDX_W-1:0] idx, input logic f);
    predicted.push_back('{k, id, v, idx, f, 1'b0});
  endfunction

  // Act on a completed length varint
  function automatic void take_length(input logic [VALUE_W-1:0] vlen);
    cat_t c;
    c  = id_class();
    ph = PH_ID;
    if (c == CAT_CID) begin
      if (vlen > MAX_CID_BYTES) begin
        err = 1'b1;
        return;
      end
      add_result(KIND_VALUE, cur_id, vlen, '0, 1'b0);
      cid_pos = '0;
    end else if (c == CAT_VAR) begin
      if (vlen == 0 || vlen > 8) begin
        err = 1'b1;
        return;
      end
      val_len = vlen[3:0];
    end else if (c == CAT_FLAG) begin
      if (vlen != 0) begin
        err = 1'b1;
        return;
      end
      add_result(KIND_VALUE, cur_id, 62'd1, '0, 1'b0);
      return;
    end
    val_left = vlen;
    if (vlen != 0) ph = PH_VALUE;
  endfunction

  // Consume one byte of a parameter value
  function automatic void take_value_byte(input logic [7:0] b);
    cat_t c;
    c = id_class();
    if (c == CAT_CID) begin
      add_result(KIND_CID_BYTE, cur_id, {54'd0, b}, cid_pos, 1'b0);
      cid_pos = cid_pos + 5'd1;
    end else if (c == CAT_VAR) begin
      if (val_left == {58'd0, val_len}) begin
        if (prefix_len(b) != val_len) begin
          err = 1'b1;
          return;
        end
        acc = {56'd0, b[5:0]};
      end else begin
        acc = {acc[53:0], b};
      end
      if (val_left == 1) begin
        if (!value_legal(acc)) begin
          err = 1'b1;
          return;
        end
        add_result(KIND_VALUE, cur_id, acc, '0, 1'b0);
      end
    end
    val_left = val_left - 62'd1;
    if (val_left == 0) ph = PH_ID;
  endfunction

  // Advance the parser by one accepted request and queue what it produces
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    int before_cnt;
    before_cnt = predicted.size();
    if (!err) begin
      if (ph == PH_VALUE) begin
        take_value_byte(b);
      end else begin
        if (vint_left == 0) begin
          vint_left = 3'(prefix_len(b) - 4'd1);
          acc       = {56'd0, b[5:0]};
        end else begin
          acc       = {acc[53:0], b};
          vint_left = vint_left - 3'd1;
        end
        if (vint_left == 0) begin
          if (ph == PH_LEN) begin
            take_length(acc);
          end else begin
            id_small = acc < 32;
            cur_id   = acc[ID_W-1:0];
            if (id_small) begin
              if (seen[cur_id]) err = 1'b1;
              seen[cur_id] = 1'b1;
            end
            ph = PH_LEN;
          end
        end
      end
    end
    if (fin) begin
      add_result(KIND_STATUS, '0, '0, '0, err || ph != PH_ID || vint_left != 0);
      clear_parser();
    end
    if (predicted.size() > before_cnt) predicted[$].last = 1'b1;
  endfunction

  function automatic void report(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  // Compare popped results, then predict from the accepted request
  always @(posedge clk) begin : watch
    param_result_t want;
    if (rst) begin
      clear_parser();
      predicted.delete();
      errors = 0;
    end else begin
      if (pop && !empty) begin
        if (predicted.size() == 0) begin
          report($sformatf("unexpected result kind=%0d id=%0d value=%0h idx=%0d failed=%0b",
                           kind, param_id, param_value, cid_index, failed));
        end else begin
          want = predicted.pop_front();
          if (kind !== want.kind || param_id !== want.id || param_value !== want.value ||
              cid_index !== want.idx || failed !== want.failed ||
              last_of_run !== want.last)
            report($sformatf({"expected kind=%0d id=%0d value=%0h idx=%0d failed=%0b ",
                              "last=%0b, got kind=%0d id=%0d value=%0h idx=%0d failed=%0b ",
                              "last=%0b"},
                             want.kind, want.id, want.value, want.idx, want.failed,
                             want.last, kind, param_id, param_value, cid_index, failed,
                             last_of_run));
        end
      end
      if (push && !full) decode_byte(data_byte, block_end);
    end
    pending = predicted.size();
  end

endmodule

[dv/quic_transport_param_parser_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the QUIC transport-parameter parser: stimulus and verdict.
module quic_transport_param_parser_tb import qtp_pkg::*;;

  typedef enum {FAULT_NONE, FAULT_VALUE, FAULT_LENGTH, FAULT_SIZE} fault_t;
  typedef enum {BLK_CLEAN, BLK_BAD_PARAM, BLK_DUPLICATE, BLK_TRUNCATED, BLK_NOISE} blk_mode_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               push      = 1'b0;
  logic [7:0]         data_byte = 8'd0;
  logic               block_end = 1'b0;
  logic               pop       = 1'b0;
  logic               full;
  logic               empty;
  logic [1:0]         kind;
  logic [ID_W-1:0]    param_id;
  logic [VALUE_W-1:0] param_value;
  logic [IDX_W-1:0]   cid_index;
  logic               failed;
  logic               last_of_run;
  int                 errors;
  int                 pending;

  bit                 calm = 1'b0;
  int                 sent = 0;
  logic [31:0]        ids_taken;
  logic [7:0]         blk_bytes[$];

  quic_transport_param_parser dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .block_end   (block_end),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .param_id    (param_id),
    .param_value (param_value),
    .cid_index   (cid_index),
    .failed      (failed),
    .last_of_run (last_of_run)
  );

  qtp_param_checker param_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .block_end   (block_end),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .param_id    (param_id),
    .param_value (param_value),
    .cid_index   (cid_index),
    .failed      (failed),
    .last_of_run (last_of_run),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold off the result side at random, except during the calm stretch
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 31);
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int min_size(input logic [63:0] v);
    if (v < 64'd64) return 1;
    if (v < 64'd16384) return 2;
    if (v < 64'd1073741824) return 4;
    return 8;
  endfunction

  // Mostly the shortest encoding, sometimes a longer one
  function automatic int pick_size(input int least);
    int s;
    s = least;
    while (s < 8 && $urandom_range(99) < 30) s = s * 2;
    return s;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] r;
    int          bits;
    bits = $urandom_range(62);
    r    = {$urandom, $urandom};
    return (bits == 0) ? 64'd0 : r >> (64 - bits);
  endfunction

  task automatic put_varint(input logic [63:0] v, input int n);
    logic [63:0] w;
    logic [63:0] code;
    int          i;
    code = (n == 1) ? 0 : (n == 2) ? 1 : (n == 4) ? 2 : 3;
    w    = v & ((64'd1 << (8 * n - 2)) - 64'd1);
    w    = w | (code << (8 * n - 2));
    for (i = n - 1; i >= 0; i--) blk_bytes.push_back(w[8 * i +: 8]);
  endtask

  // Reserve an unused id of the given class, or -1 if none turns up
  function automatic int claim_id(input cat_t cls);
    int k;
    int id;
    int tries;
    for (tries = 0; tries < 8; tries++) begin
      case (cls)
        CAT_VAR: begin
          k  = $urandom_range(10);
          id = (k == 0) ? 1 : (k == 10) ? int'(ID_CID_LIMIT) : k + 2;
        end
        CAT_CID: begin
          k  = $urandom_range(2);
          id = (k == 0) ? int'(ID_ORIG_DCID) : (k == 1) ? int'(ID_INIT_SCID)
                                                        : int'(ID_RETRY_SCID);
        end
        CAT_FLAG: id = ID_MIGRATION;
        default: begin
          k  = $urandom_range(16);
          id = (k == 0) ? 2 : (k == 1) ? 13 : k + 15;
        end
      endcase
      if (!ids_taken[id]) begin
        ids_taken[id] = 1'b1;
        return id;
      end
    end
    return -1;
  endfunction

  // Value for a varint parameter, near its limit half of the time
  function automatic logic [63:0] value_for(input logic [ID_W-1:0] id, input bit bad);
    bit near;
    near = 1'($urandom_range(1));
    case (id)
      ID_MAX_UDP_PAYLOAD:
        if (bad) return near ? MIN_UDP_PAYLOAD - 1 : $urandom_range(1199);
        else return near ? MIN_UDP_PAYLOAD : $urandom_range(65527, 1200);
      ID_ACK_DELAY_EXP:
        if (bad) return near ? MAX_ACK_EXP + 1 : $urandom_range(63, 21);
        else return near ? MAX_ACK_EXP : $urandom_range(20);
      ID_MAX_ACK_DELAY:
        if (bad) return near ? ACK_DELAY_LIMIT : $urandom_range(40000, 16384);
        else return near ? ACK_DELAY_LIMIT - 1 : $urandom_range(16383);
      ID_CID_LIMIT:
        if (bad) return near ? MIN_CID_LIMIT - 1 : $urandom_range(1);
        else return near ? MIN_CID_LIMIT : $urandom_range(1000, 2);
      default: return random_value();
    endcase
  endfunction

  // Append one parameter of the given class, with a fault if bad is set
  task automatic add_param(input cat_t cls, input bit bad);
    cat_t        c;
    fault_t      fault;
    int          id;
    int          n;
    int          len;
    int          i;
    logic [63:0] pid;
    logic [63:0] v;
    c  = cls;
    id = (c == CAT_SKIP && $urandom_range(1)) ? -1 : claim_id(c);
    if (id < 0) begin
      c   = CAT_SKIP;
      pid = 64'($urandom_range(32'h3FFF_FFFF, 32));
    end else begin
      pid = 64'(id);
    end
    put_varint(pid, pick_size(min_size(pid)));
    case (c)
      CAT_VAR: begin
        fault = bad ? fault_t'($urandom_range(FAULT_SIZE, FAULT_VALUE)) : FAULT_NONE;
        v     = value_for(pid[ID_W-1:0], fault == FAULT_VALUE);
        n     = pick_size(min_size(v));
        if (fault == FAULT_LENGTH) len = $urandom_range(1) ? 0 : $urandom_range(63, 9);
        else len = n;
        put_varint(len, pick_size(min_size(len)));
        // encode with a size the length does not announce
        if (fault == FAULT_SIZE) n = (n == 8) ? 1 : n * 2;
        put_varint(v, n);
      end
      CAT_CID: begin
        if (bad) len = $urandom_range(63, 21);
        else len = ($urandom_range(7) == 0) ? MAX_CID_BYTES_DEF : $urandom_range(8);
        put_varint(len, pick_size(min_size(len)));
        for (i = 0; i < (bad ? 2 : len); i++) blk_bytes.push_back(8'($urandom));
      end
      CAT_FLAG: begin
        len = bad ? $urandom_range(5, 1) : 0;
        put_varint(len, pick_size(1));
        for (i = 0; i < len; i++) blk_bytes.push_back(8'($urandom));
      end
      default: begin
        len = $urandom_range(6);
        put_varint(len, pick_size(1));
        for (i = 0; i < len; i++) blk_bytes.push_back(8'($urandom));
      end
    endcase
  endtask

  // Build one block: mostly well formed, otherwise broken in one way
  task automatic build_block(input bit faulty);
    blk_mode_t       mode;
    cat_t            cls;
    int              np;
    int              p;
    int              r;
    int              cut;
    logic [ID_W-1:0] dup;
    ids_taken = '0;
    mode = faulty ? blk_mode_t'($urandom_range(BLK_NOISE, BLK_BAD_PARAM)) : BLK_CLEAN;
    if (mode == BLK_NOISE) begin
      repeat ($urandom_range(10, 1)) blk_bytes.push_back(8'($urandom));
    end else begin
      np = $urandom_range(5, 1);
      for (p = 0; p < np; p++) begin
        r   = $urandom_range(9);
        cls = (r < 5) ? CAT_VAR : (r < 7) ? CAT_CID : (r < 8) ? CAT_FLAG : CAT_SKIP;
        add_param(cls, mode == BLK_BAD_PARAM && p == np - 1);
      end
      if (mode == BLK_DUPLICATE) begin
        // repeat an id the block already carries
        if (ids_taken == 0) add_param(CAT_FLAG, 1'b0);
        do dup = ID_W'($urandom); while (!ids_taken[dup]);
        put_varint(dup, 1);
        put_varint(0, 1);
      end
      if (mode == BLK_TRUNCATED && blk_bytes.size() > 1) begin
        cut = $urandom_range(blk_bytes.size() - 1, 1);
        repeat (cut) void'(blk_bytes.pop_back());
      end
    end
  endtask

  // Offer one request, idling at random first; return once it is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < 31) begin
      push      <= 1'b0;
      data_byte <= 8'($urandom);
      block_end <= 1'($urandom);
      @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    block_end <= fin;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic send_block();
    int i;
    for (i = 0; i < blk_bytes.size(); i++) send_byte(blk_bytes[i], i == blk_bytes.size() - 1);
    blk_bytes.delete();
  endtask

  // Hold the sender until every predicted result has come out
  task automatic wait_drained();
    int spins;
    spins = 0;
    push <= 1'b0;
    do begin
      @(negedge clk);
      spins++;
    end while (pending != 0 && spins < 50000);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int blk;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Migration flag: value and status from the same byte
    put_varint(ID_MIGRATION, 1);
    put_varint(0, 1);
    send_block();
    // One-byte connection ID with an all-ones byte
    put_varint(ID_ORIG_DCID, 1);
    put_varint(1, 1);
    blk_bytes.push_back(8'hFF);
    send_block();
    // Connection-ID limit below its minimum
    put_varint(ID_CID_LIMIT, 1);
    put_varint(1, 1);
    put_varint(1, 1);
    send_block();
    // Block ends inside a value
    put_varint(1, 1);
    put_varint(8, 1);
    blk_bytes.push_back(8'hC0);
    send_block();
    // Same id twice
    put_varint(ID_MIGRATION, 1);
    put_varint(0, 1);
    put_varint(ID_MIGRATION, 1);
    send_block();
    // Largest eight-byte value
    put_varint(4, 1);
    put_varint(8, 1);
    put_varint(64'h3FFF_FFFF_FFFF_FFFF, 8);
    send_block();
    // Value varint shorter than its length
    put_varint(ID_ACK_DELAY_EXP, 1);
    put_varint(2, 1);
    put_varint(5, 1);
    send_block();

    // Random blocks, with a calm stretch and two full drains
    blk = 0;
    while (sent < 1200) begin
      calm = (blk >= 30 && blk < 60);
      if (blk == 15 || blk == 90) wait_drained();
      build_block($urandom_range(99) < 25);
      send_block();
      blk++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/qtp_pkg.sv
hdl/qtp_front.sv
hdl/qtp_fifo.sv
hdl/qtp_back.sv
hdl/quic_transport_param_parser.sv
dv/qtp_param_checker.sv
dv/quic_transport_param_parser_tb.sv
